// ----- hdl/smd_pkg.sv -----
// Shared types and widths for the small matrix determinant block.
package smd_pkg;

  localparam int ELEM_W = 12;
  localparam int DET_W  = 50;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [DET_W-1:0]  det_t;

  // Control that travels with one product term down the multiply-accumulate pipe.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic neg;
  } term_ctrl_t;

  // Finished minor coming back from the multiply-accumulate unit.
  typedef struct packed {
    logic done;
    det_t value;
  } mac_res_t;

endpackage

// ----- hdl/smd_elem_if.sv -----
// Valid/ready channel that carries one matrix element per word.
interface smd_elem_if;
  logic           valid;
  logic           ready;
  smd_pkg::elem_t element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

// ----- hdl/smd_det_if.sv -----
// Valid/ready channel that carries one determinant per word.
interface smd_det_if;
  logic          valid;
  logic          ready;
  smd_pkg::det_t det_value;

  modport source (output valid, output det_value, input ready);
  modport sink   (input valid, input det_value, output ready);
endinterface

// ----- hdl/smd_mac.sv -----
// Two-stage signed multiply-accumulate unit shared by all cofactor terms.
module smd_mac (
  input  logic                clk,
  input  logic                rst,
  input  smd_pkg::term_ctrl_t ctrl,
  input  smd_pkg::elem_t      elem,
  input  smd_pkg::det_t       operand,
  output smd_pkg::mac_res_t   res
);

  logic signed [smd_pkg::ELEM_W+smd_pkg::DET_W-1:0] full;
  smd_pkg::term_ctrl_t ctrl_p;
  smd_pkg::det_t       prod;
  smd_pkg::det_t       acc;
  smd_pkg::det_t       base;
  smd_pkg::det_t       sum;

  // Only the low bits are kept; every minor fits the result width exactly.
  assign full = elem * operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_p <= '0;
    end else begin
      ctrl_p <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    prod <= full[smd_pkg::DET_W-1:0];
    if (ctrl_p.valid) begin
      acc <= sum;
    end
  end

  always_comb begin
    base = ctrl_p.first ? '0 : acc;
    sum  = ctrl_p.neg ? base - prod : base + prod;
  end

  assign res = '{done: ctrl_p.valid && ctrl_p.last, value: sum};

endmodule

// ----- hdl/small_matrix_determinant_top.sv -----
// Top level of the streaming small matrix determinant block.
//
//   Channel  Direction  Payload               Handshake
//   elem     in         element, 12b signed   valid/ready
//   det      out        det_value, 50b signed valid/ready
//
// Elements load one word per cycle in row-major order. After the last word the block
// computes the determinant and is not ready meanwhile; one shared multiply-accumulate
// unit takes one product per cycle while terms issue, and each minor drains from it
// before the next begins. Reset is synchronous and clears the load position and
// control only; the stores are not cleared. A waiting result holds in its register while
// the next matrix loads, and only that matrix's last word is held off until it is taken.
module small_matrix_determinant_top #(
  parameter int SIZE = 4
) (
  input logic        clk,
  input logic        rst,
  smd_elem_if.sink   elem,
  smd_det_if.source  det
);

  // The determinant is built bottom-up as minors indexed by their column set.
  // The minor for column set S uses the rows from SIZE-|S| down, and it is
  // the alternating sum over columns c in S of A[row][c] * minor(S without c).
  // Visiting the sets in increasing numeric order guarantees that every smaller
  // minor is already stored, and the empty set counts as one. The final set,
  // with every column, is the determinant itself.

  localparam int NELEM = SIZE * SIZE;
  localparam int PW    = (NELEM > 1) ? $clog2(NELEM) : 1;
  localparam int CW    = (SIZE > 1) ? $clog2(SIZE) : 1;
  localparam logic [PW-1:0]   LAST_POS = PW'(NELEM - 1);
  localparam logic [SIZE-1:0] FULL     = '1;

  typedef enum logic [1:0] {LOAD, ISSUE, DRAIN} state_t;

  state_t                state;
  logic [PW-1:0]         pos;
  logic [SIZE-1:0]       m;
  logic [SIZE-1:0]       cbits;
  logic                  neg;
  logic                  first_pend;
  logic                  out_valid;
  smd_pkg::det_t         det_q;

  logic                  acc_in;
  logic [CW-1:0]         col;
  logic [CW:0]           pop;
  logic [CW:0]           row_w;
  logic [CW-1:0]         row;
  logic [SIZE-1:0]       cbits_rest;
  logic [SIZE-1:0]       ma;
  logic [PW-1:0]         ea;

  smd_pkg::elem_t        mstore [NELEM];
  smd_pkg::det_t         minor_mem [2**SIZE];
  smd_pkg::elem_t        elem_q;
  smd_pkg::det_t         minor_q;
  logic                  empty_q;
  smd_pkg::det_t         operand;
  smd_pkg::term_ctrl_t   term_q;
  smd_pkg::mac_res_t     res;

  function automatic logic [CW:0] count_cols(logic [SIZE-1:0] mask);
    logic [CW:0] n;
    n = '0;
    for (int i = 0; i < SIZE; i++) begin
      n = n + (CW+1)'(mask[i]);
    end
    return n;
  endfunction

  // Handshakes. The last word of a matrix waits while an old result is unread.
  assign elem.ready = (state == LOAD) && !((pos == LAST_POS) && out_valid);
  assign acc_in     = elem.valid && elem.ready;
  assign det.valid     = out_valid;
  assign det.det_value = det_q;

  // Next term: lowest remaining column of the current set, its row and addresses.
  always_comb begin
    col = '0;
    for (int i = SIZE - 1; i >= 0; i--) begin
      if (cbits[i]) begin
        col = CW'(i);
      end
    end
    pop        = count_cols(m);
    row_w      = (CW+1)'(SIZE) - pop;
    row        = row_w[CW-1:0];
    cbits_rest = cbits & ~(SIZE'(1) << col);
    ma         = m & ~(SIZE'(1) << col);
    ea         = PW'(row * SIZE + col);
  end

  // Sequencer: loads the matrix, then walks the column sets one term a cycle while issuing, draining after each set.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= LOAD;
      pos        <= '0;
      m          <= '0;
      cbits      <= '0;
      neg        <= 1'b0;
      first_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && det.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        LOAD: begin
          if (acc_in) begin
            if (pos == LAST_POS) begin
              pos        <= '0;
              m          <= SIZE'(1);
              cbits      <= SIZE'(1);
              neg        <= 1'b0;
              first_pend <= 1'b1;
              state      <= ISSUE;
            end else begin
              pos <= pos + 1'b1;
            end
          end
        end
        ISSUE: begin
          cbits      <= cbits_rest;
          neg        <= ~neg;
          first_pend <= 1'b0;
          if (cbits_rest == '0) begin
            state <= DRAIN;
          end
        end
        DRAIN: begin
          if (res.done) begin
            if (m == FULL) begin
              out_valid <= 1'b1;
              det_q     <= res.value;
              state     <= LOAD;
            end else begin
              m          <= m + 1'b1;
              cbits      <= m + 1'b1;
              neg        <= 1'b0;
              first_pend <= 1'b1;
              state      <= ISSUE;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  // Control for the term whose operands are being read this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      term_q <= '0;
    end else begin
      term_q <= '{valid: (state == ISSUE), first: first_pend,
                  last: (cbits_rest == '0), neg: neg};
    end
  end

  // Matrix store: written while loading, read one element per term.
  always_ff @(posedge clk) begin
    if (acc_in) begin
      mstore[pos] <= elem.element;
    end
    elem_q <= mstore[ea];
  end

  // Minor store: one entry per column set, written when a minor completes.
  always_ff @(posedge clk) begin
    if (res.done) begin
      minor_mem[m] <= res.value;
    end
    minor_q <= minor_mem[ma];
    empty_q <= (ma == '0);
  end

  assign operand = empty_q ? smd_pkg::det_t'(1) : minor_q;

  smd_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (term_q),
    .elem    (elem_q),
    .operand (operand),
    .res     (res)
  );

`ifndef SYNTH
  // A matrix never completes on top of a result that has not been taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (acc_in && (pos == LAST_POS)) |-> !out_valid)
    else $error("last word accepted while a result is pending");

  // A minor completes only after all of its terms have been issued.
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    res.done |-> (state == DRAIN))
    else $error("minor completed while terms were still being issued");

  // Issuing always has at least one column left in the current set.
  a_issue_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ISSUE) |-> (cbits != '0))
    else $error("issue with an empty column set");

  // A result appears only when the full column set has just finished.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == DRAIN) && ($past(m) == FULL))
    else $error("result raised outside the final minor");
`endif

endmodule

// ----- tb/smd_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts each determinant from the element stream and compares the results.
module smd_checker #(
  parameter int MAT_N = 4
) (
  input  logic        clk,
  input  logic        rst,
  smd_elem_if         elem,
  smd_det_if          det,
  output int unsigned fail_count,
  output int unsigned dets_owed,
  output int unsigned dets_seen,
  output int unsigned words_seen
);

  localparam int MAX_REPORTS = 10;

  smd_pkg::elem_t loaded [16];
  int unsigned    load_idx = 0;
  smd_pkg::det_t  det_expected_q [$];
  smd_pkg::det_t  want;
  int unsigned    n_fail = 0;
  int unsigned    n_dets = 0;
  int unsigned    n_words = 0;

  // 3x3 determinant of rows 1..3 with column skip removed, on a padded 4x4.
  function automatic longint minor3_of(input longint a [16], input int skip);
    int col [3];
    int k;
    k = 0;
    for (int c = 0; c < 4; c++) begin
      if (c != skip) begin
        col[k] = c;
        k++;
      end
    end
    return a[4+col[0]] * (a[8+col[1]] * a[12+col[2]] - a[8+col[2]] * a[12+col[1]])
         - a[4+col[1]] * (a[8+col[0]] * a[12+col[2]] - a[8+col[2]] * a[12+col[0]])
         + a[4+col[2]] * (a[8+col[0]] * a[12+col[1]] - a[8+col[1]] * a[12+col[0]]);
  endfunction

  // A smaller matrix is padded with an identity block, which leaves its determinant unchanged.
  function automatic smd_pkg::det_t det_of(input smd_pkg::elem_t m [16]);
    longint a [16];
    longint acc;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (r < MAT_N && c < MAT_N) begin
          a[r*4+c] = longint'(m[r*MAT_N+c]);
        end else begin
          a[r*4+c] = (r == c) ? 64'sd1 : 64'sd0;
        end
      end
    end
    acc = 0;
    for (int c = 0; c < 4; c++) begin
      if (c % 2 == 0) begin
        acc += a[c] * minor3_of(a, c);
      end else begin
        acc -= a[c] * minor3_of(a, c);
      end
    end
    return smd_pkg::det_t'(acc);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      load_idx = 0;
    end else begin
      if (elem.valid === 1'b1 && elem.ready === 1'b1) begin
        loaded[load_idx] = elem.element;
        n_words++;
        if (load_idx == MAT_N * MAT_N - 1) begin
          det_expected_q.push_back(det_of(loaded));
          load_idx = 0;
        end else begin
          load_idx++;
        end
      end
      if (det.valid === 1'b1 && det.ready === 1'b1) begin
        if (det_expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("%0t: determinant %0d arrived with none outstanding", $realtime,
                     det.det_value);
          end
        end else begin
          want = det_expected_q.pop_front();
          n_dets++;
          if (det.det_value !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS) begin
              $display("%0t: det_value mismatch, expected %0d got %0d", $realtime, want,
                       det.det_value);
            end
          end
        end
      end
    end
    fail_count <= n_fail;
    dets_owed  <= det_expected_q.size();
    dets_seen  <= n_dets;
    words_seen <= n_words;
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the small matrix determinant block: clock, reset, stimulus and verdict.
module tb_top;

  // Matrix dimension under test and the number of words that make up one matrix.
  localparam int MAT_N          = 4;
  localparam int MAT_WORDS      = MAT_N * MAT_N;
  // Random matrices sent in each of the three stall mixes (about 1300 words in all).
  localparam int MATS_PER_PHASE = 27;
  // Cycles with no word moving on either channel before the run is declared hung.
  // No word moves while a 4x4 computes, and the receiver may stall on top of that.
  localparam int QUIET_LIMIT    = 4000;
  // Settling time after the last determinant, a little longer than one computation.
  localparam int DRAIN_CYCLES   = 70;

  localparam smd_pkg::elem_t ELEM_MAX = smd_pkg::elem_t'(2047);
  localparam smd_pkg::elem_t ELEM_MIN = smd_pkg::elem_t'(-2048);

  // Kinds of random matrix. Full-range fills dominate; the others steer toward small
  // values, exact zeros (singular), very large results (triangular with extreme
  // diagonal), sparse products and the corner values of the element field.
  typedef enum int {
    SHAPE_FULL,
    SHAPE_SMALL,
    SHAPE_CORNER,
    SHAPE_SPARSE,
    SHAPE_SINGULAR,
    SHAPE_TRIANGULAR
  } shape_e;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  int unsigned    src_idle_pct;
  int unsigned    sink_idle_pct;
  int unsigned    quiet_cycles = 0;
  int unsigned    fail_count;
  int unsigned    dets_owed;
  int unsigned    dets_seen;
  int unsigned    words_seen;
  smd_pkg::elem_t mat [16];

  smd_elem_if elem_ch ();
  smd_det_if  det_ch ();

  small_matrix_determinant_top #(.SIZE(MAT_N)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .elem (elem_ch),
    .det  (det_ch)
  );

  // The checker watches both channels on its own and reports back only counts.
  smd_checker #(.MAT_N(MAT_N)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .elem       (elem_ch),
    .det        (det_ch),
    .fail_count (fail_count),
    .dets_owed  (dets_owed),
    .dets_seen  (dets_seen),
    .words_seen (words_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver drops ready at random each cycle with the current idle percentage.
  // With a zero percentage the comparison always passes, so ready stays high.
  always @(posedge clk) begin
    det_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Watchdog: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (elem_ch.valid && elem_ch.ready) || (det_ch.valid && det_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", QUIET_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One element per call. Idle cycles are inserted before the word is offered; once
  // offered, valid holds until the block takes it. Ready is sampled as it stood just
  // before the edge, which is the value the block used to accept the word.
  task automatic send_word(input smd_pkg::elem_t value);
    while ($urandom_range(99) < src_idle_pct) begin
      elem_ch.valid <= 1'b0;
      @(posedge clk);
    end
    elem_ch.valid   <= 1'b1;
    elem_ch.element <= value;
    do @(posedge clk); while (elem_ch.ready !== 1'b1);
  endtask

  task automatic send_matrix();
    for (int i = 0; i < MAT_WORDS; i++) begin
      send_word(mat[i]);
    end
  endtask

  function automatic smd_pkg::elem_t corner_elem();
    case ($urandom_range(4))
      0:       return ELEM_MIN;
      1:       return smd_pkg::elem_t'(-1);
      2:       return smd_pkg::elem_t'(0);
      3:       return smd_pkg::elem_t'(1);
      default: return ELEM_MAX;
    endcase
  endfunction

  task automatic fill_random_matrix();
    shape_e      shape;
    int unsigned pick;
    int unsigned src_row;
    int unsigned dst_row;
    pick  = $urandom_range(9);
    shape = (pick >= 5) ? shape_e'(pick - 4) : SHAPE_FULL;
    for (int i = 0; i < MAT_WORDS; i++) begin
      case (shape)
        SHAPE_SMALL:  mat[i] = smd_pkg::elem_t'(int'($urandom_range(6)) - 3);
        SHAPE_CORNER: mat[i] = corner_elem();
        SHAPE_SPARSE: mat[i] = ($urandom_range(3) == 0) ? smd_pkg::elem_t'($urandom)
                                                         : smd_pkg::elem_t'(0);
        default:      mat[i] = smd_pkg::elem_t'($urandom);
      endcase
    end
    // A repeated row forces a zero determinant with otherwise random content.
    if (shape == SHAPE_SINGULAR && MAT_N > 1) begin
      src_row = $urandom_range(MAT_N - 1);
      dst_row = (src_row + 1 + $urandom_range(MAT_N - 2)) % MAT_N;
      for (int c = 0; c < MAT_N; c++) begin
        mat[dst_row*MAT_N+c] = mat[src_row*MAT_N+c];
      end
    end
    // Upper triangular with extreme diagonal pushes the result toward the top of its range.
    if (shape == SHAPE_TRIANGULAR) begin
      for (int r = 0; r < MAT_N; r++) begin
        for (int c = 0; c < MAT_N; c++) begin
          if (c < r) begin
            mat[r*MAT_N+c] = smd_pkg::elem_t'(0);
          end else if (c == r) begin
            mat[r*MAT_N+c] = $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
          end
        end
      end
    end
  endtask

  // Returns once every determinant owed so far has been taken. The first edge lets the
  // checker record the last accepted word before its outstanding count is trusted.
  task automatic wait_all_dets();
    do @(posedge clk); while (dets_owed != 0);
  endtask

  // One stall mix: random matrices back to back, then the sender holds off until the
  // block has handed over every result, so the next mix starts from an idle block.
  task automatic run_phase(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int m = 0; m < MATS_PER_PHASE; m++) begin
      fill_random_matrix();
      send_matrix();
    end
    elem_ch.valid <= 1'b0;
    wait_all_dets();
  endtask

  initial begin
    elem_ch.valid   = 1'b0;
    elem_ch.element = '0;
    src_idle_pct    = 15;
    sink_idle_pct   = 66;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. First a Sylvester-Hadamard sign pattern built from the two extreme
    // element values: near the largest determinant magnitude, with every product term
    // at full width and both signs in every row but the first.
    for (int r = 0; r < MAT_N; r++) begin
      for (int c = 0; c < MAT_N; c++) begin
        mat[r*MAT_N+c] = ($countones(r & c) % 2 == 1) ? ELEM_MIN : ELEM_MAX;
      end
    end
    send_matrix();
    // Then a diagonal of the most negative value with zeros elsewhere. It follows the
    // first matrix directly, so the load position has to wrap back to the start.
    for (int r = 0; r < MAT_N; r++) begin
      for (int c = 0; c < MAT_N; c++) begin
        mat[r*MAT_N+c] = (r == c) ? ELEM_MIN : smd_pkg::elem_t'(0);
      end
    end
    send_matrix();

    // Random part under three stall mixes: mostly receiver stalls, mostly sender gaps,
    // then full throughput with neither side idling.
    run_phase(15, 66);
    run_phase(66, 15);
    run_phase(0, 0);

    // Give the block time to show any stray result before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d words in %0d-by-%0d matrices, %0d determinants compared.",
             words_seen, MAT_N, MAT_N, dets_seen);
    $display("Covered extreme Hadamard and diagonal cases, then random, singular, sparse, "
             , "triangular and corner-value matrices under three stall mixes.");
    if (fail_count == 0 && dets_owed == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/smd_pkg.sv
hdl/smd_elem_if.sv
hdl/smd_det_if.sv
hdl/smd_mac.sv
hdl/small_matrix_determinant_top.sv
tb/smd_checker.sv
tb/tb_top.sv
